// ----- sv/mgr_pkg.sv -----
// Shared constants and codes for the 2:1 multigrid restriction block.
package mgr_pkg;

  // configuration register width and indexes
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COARSE_WIDTH  = 2'd0,
    CFG_COARSE_HEIGHT = 2'd1,
    CFG_STAGGER_X     = 2'd2,
    CFG_STAGGER_Y     = 2'd3
  } cfg_idx_e;

  // row axis is capped at 1024 coarse rows
  localparam int HEIGHT_LIMIT = 1024;
  localparam int NY_W         = 11;  // holds 1..HEIGHT_LIMIT
  localparam int FROW_W       = 11;  // fine row counter
  localparam int CROW_W       = 10;  // coarse row index
  localparam int COORD_W      = 10;  // width of emitted coordinates

  // rounding of the 1/64 scaled sum
  localparam int ROUND_BIAS = 32;
  localparam int FRAC_SHIFT = 6;

  // output queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

endpackage

// ----- sv/mgr_out_fifo.sv -----
// Small result queue that decouples the accumulator pipeline from the output stall.
module mgr_out_fifo #(
  parameter int DATA_W = 53
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [DATA_W-1:0]              push_data_i,
  output logic [mgr_pkg::FIFO_CNT_W-1:0] count_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [DATA_W-1:0]              out_data_o
);
  import mgr_pkg::*;

  logic [DATA_W-1:0]     buf_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_data_o  = buf_q[rd_ptr_q];
  assign count_o     = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + FIFO_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - FIFO_CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- sv/multigrid_restriction_2d.sv -----
// Top level of the streaming 2:1 multigrid restriction (full weighting, per-axis stagger).
// Takes one fine sample per cycle in raster order and emits at most one coarse value per
// sample, registered in stage 1 and then queued. The horizontal sums sit in two registers;
// the vertical sums sit in two accumulator banks (one per coarse row parity, MAX_COARSE_WIDTH
// entries of SAMPLE_BITS+12 bits each) that are read when a horizontal sum completes and
// written back in the following cycle, with a bypass of the previous write so back-to-back
// hits on the same column cost nothing. The sustained rate is one sample per cycle; in_stall_o
// rises only while the four-entry output queue has no room for results still in flight.
// Accumulator entries need no clearing: each is written by its first tap.
module multigrid_restriction_2d #(
  parameter int MAX_COARSE_WIDTH = 1024,
  parameter int SAMPLE_BITS      = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mgr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mgr_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]     sample_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]     coarse_value_o,
  output logic [mgr_pkg::COORD_W-1:0]       coarse_col_o,
  output logic [mgr_pkg::COORD_W-1:0]       coarse_row_o,
  output logic                              frame_last_o
);
  import mgr_pkg::*;

  localparam int FCW    = $clog2(2 * MAX_COARSE_WIDTH);  // fine column counter
  localparam int CIW    = FCW - 1;                        // coarse column index
  localparam int NXW    = $clog2(MAX_COARSE_WIDTH + 1);
  localparam int HSUM_W = SAMPLE_BITS + 8;
  localparam int ACC_W  = SAMPLE_BITS + 12;
  localparam int RES_W  = SAMPLE_BITS + 2 * COORD_W + 1;

  typedef enum logic [1:0] {WGT_ONE, WGT_THREE, WGT_FOUR, WGT_EIGHT} wgt_e;

  typedef struct packed {
    logic en;
    logic first;
    wgt_e wgt;
  } bank_op_t;

  function automatic logic signed [ACC_W-1:0] scale(input logic signed [ACC_W-1:0] v,
                                                    input wgt_e w);
    logic signed [ACC_W-1:0] r;
    case (w)
      WGT_ONE:   r = v;
      WGT_THREE: r = v + (v <<< 1);
      WGT_FOUR:  r = v <<< 2;
      WGT_EIGHT: r = v <<< 3;
    endcase
    return r;
  endfunction

  // ---------------- configuration ----------------
  logic [CFG_W-1:0] cfg_width_q, cfg_height_q;
  logic             cfg_stag_x_q, cfg_stag_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= CFG_W'(1);
      cfg_height_q <= CFG_W'(1);
      cfg_stag_x_q <= 1'b0;
      cfg_stag_y_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_COARSE_WIDTH:  cfg_width_q  <= cfg_data_i;
        CFG_COARSE_HEIGHT: cfg_height_q <= cfg_data_i;
        CFG_STAGGER_X:     cfg_stag_x_q <= cfg_data_i[0];
        CFG_STAGGER_Y:     cfg_stag_y_q <= cfg_data_i[0];
      endcase
    end
  end

  logic [NXW-1:0]  nx;
  logic [NY_W-1:0] ny;
  logic [FCW:0]    fw;
  logic [FROW_W:0] fh;

  always_comb begin
    if (cfg_width_q == '0) begin
      nx = NXW'(1);
    end else if (32'(cfg_width_q) > 32'(MAX_COARSE_WIDTH)) begin
      nx = NXW'(MAX_COARSE_WIDTH);
    end else begin
      nx = NXW'(cfg_width_q);
    end
    if (cfg_height_q == '0) begin
      ny = NY_W'(1);
    end else if (32'(cfg_height_q) > 32'(HEIGHT_LIMIT)) begin
      ny = NY_W'(HEIGHT_LIMIT);
    end else begin
      ny = NY_W'(cfg_height_q);
    end
    fw = (FCW+1)'({nx, 1'b0}) - (FCW+1)'(cfg_stag_x_q);
    fh = (FROW_W+1)'({ny, 1'b0}) - (FROW_W+1)'(cfg_stag_y_q);
  end

  // ---------------- stage 0: counters and horizontal sums ----------------
  logic                    in_acc;
  logic [FCW-1:0]          x_q, x_eff;
  logic [FROW_W-1:0]       y_q, y_eff;
  logic [FCW:0]            x_inc;
  logic [FROW_W:0]         y_inc;
  logic [CIW-1:0]          kx;
  logic [CROW_W-1:0]       ky;
  logic signed [HSUM_W-1:0] hs0_q, hs1_q, hs0_d, hs1_d;
  logic signed [ACC_W-1:0] s_ext, hs_cur, hs_oth, new_cur, new_oth;
  logic                    wr_cur, wr_oth;
  logic                    h_done;
  logic signed [ACC_W-1:0] h_val;
  logic [CIW-1:0]          h_col;
  logic                    x_last_col, y_last_row;

  assign in_acc = in_valid_i && !in_stall_o;

  always_comb begin
    x_eff = ({1'b0, x_q} >= fw) ? '0 : x_q;
    y_eff = ({1'b0, y_q} >= fh) ? '0 : y_q;
    x_inc = (FCW+1)'(x_eff) + (FCW+1)'(1);
    y_inc = (FROW_W+1)'(y_eff) + (FROW_W+1)'(1);
    kx    = x_eff[FCW-1:1];
    ky    = y_eff[FROW_W-1:1];
    x_last_col = (32'(kx) + 32'd1) == 32'(nx);
    y_last_row = (32'(ky) + 32'd1) == 32'(ny);
  end

  // horizontal taps: "cur" is the sum of coarse column kx, "oth" the other parity
  always_comb begin
    s_ext   = ACC_W'(sample_i);
    hs_cur  = kx[0] ? ACC_W'(hs1_q) : ACC_W'(hs0_q);
    hs_oth  = kx[0] ? ACC_W'(hs0_q) : ACC_W'(hs1_q);
    new_cur = '0;
    new_oth = '0;
    wr_cur  = 1'b0;
    wr_oth  = 1'b0;
    h_done  = 1'b0;
    h_val   = '0;
    h_col   = kx;
    if (cfg_stag_x_q) begin
      if (!x_eff[0]) begin
        new_cur = scale(s_ext, WGT_EIGHT);
        wr_cur  = 1'b1;
        h_done  = 1'b1;
        h_val   = new_cur;
      end
    end else if (!x_eff[0]) begin
      wr_cur  = 1'b1;
      new_cur = (kx == '0) ? scale(s_ext, WGT_FOUR) : hs_cur + scale(s_ext, WGT_THREE);
      if (kx != '0) begin
        // closing tap of the column to the left
        new_oth = hs_oth + s_ext;
        wr_oth  = 1'b1;
        h_done  = 1'b1;
        h_val   = new_oth;
        h_col   = kx - CIW'(1);
      end
    end else begin
      wr_cur  = 1'b1;
      new_cur = hs_cur + scale(s_ext, x_last_col ? WGT_FOUR : WGT_THREE);
      if (x_last_col) begin
        h_done = 1'b1;
        h_val  = new_cur;
      end else begin
        new_oth = s_ext;
        wr_oth  = 1'b1;
      end
    end
    hs0_d = hs0_q;
    hs1_d = hs1_q;
    if (wr_cur) begin
      if (kx[0]) hs1_d = HSUM_W'(new_cur);
      else       hs0_d = HSUM_W'(new_cur);
    end
    if (wr_oth) begin
      if (kx[0]) hs0_d = HSUM_W'(new_oth);
      else       hs1_d = HSUM_W'(new_oth);
    end
  end

  // vertical taps for a completed horizontal sum, split by row parity bank
  bank_op_t          op_cur, op_oth, op0, op1;
  logic              res_valid, res_on_cur, res_bank, res_flast;
  logic [CROW_W-1:0] res_row;

  always_comb begin
    op_cur     = '{en: 1'b0, first: 1'b0, wgt: WGT_ONE};
    op_oth     = '{en: 1'b0, first: 1'b0, wgt: WGT_ONE};
    res_valid  = 1'b0;
    res_on_cur = 1'b1;
    res_row    = ky;
    if (cfg_stag_y_q) begin
      if (!y_eff[0]) begin
        op_cur    = '{en: 1'b1, first: 1'b1, wgt: WGT_EIGHT};
        res_valid = 1'b1;
      end
    end else if (!y_eff[0]) begin
      op_cur = '{en: 1'b1, first: (ky == '0), wgt: (ky == '0) ? WGT_FOUR : WGT_THREE};
      if (ky != '0) begin
        op_oth     = '{en: 1'b1, first: 1'b0, wgt: WGT_ONE};
        res_valid  = 1'b1;
        res_on_cur = 1'b0;
        res_row    = ky - CROW_W'(1);
      end
    end else begin
      op_cur = '{en: 1'b1, first: 1'b0, wgt: y_last_row ? WGT_FOUR : WGT_THREE};
      if (y_last_row) begin
        res_valid = 1'b1;
      end else begin
        op_oth = '{en: 1'b1, first: 1'b1, wgt: WGT_ONE};
      end
    end
    op0       = ky[0] ? op_oth : op_cur;
    op1       = ky[0] ? op_cur : op_oth;
    res_bank  = ky[0] ^ !res_on_cur;
    res_flast = ((32'(h_col) + 32'd1) == 32'(nx)) && ((32'(res_row) + 32'd1) == 32'(ny));
  end

  logic rd_en;
  assign rd_en = in_acc && h_done && (op_cur.en || op_oth.en);

  // stage 1 registers
  logic                     s1_valid_q;
  logic signed [HSUM_W-1:0] s1_h_q;
  logic [CIW-1:0]           s1_col_q;
  bank_op_t                 s1_op_q [2];
  logic                     s1_res_valid_q, s1_res_bank_q, s1_flast_q;
  logic [CROW_W-1:0]        s1_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q        <= '0;
      y_q        <= '0;
      hs0_q      <= '0;
      hs1_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= rd_en;
      if (in_acc) begin
        hs0_q <= hs0_d;
        hs1_q <= hs1_d;
        if (x_inc >= fw) begin
          x_q <= '0;
          y_q <= (y_inc >= fh) ? '0 : FROW_W'(y_inc);
        end else begin
          x_q <= FCW'(x_inc);
          y_q <= y_eff;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_h_q         <= HSUM_W'(h_val);
      s1_col_q       <= h_col;
      s1_op_q[0]     <= op0;
      s1_op_q[1]     <= op1;
      s1_res_valid_q <= res_valid;
      s1_res_bank_q  <= res_bank;
      s1_row_q       <= res_row;
      s1_flast_q     <= res_flast;
    end
  end

  // ---------------- stage 1: accumulator banks ----------------
  logic signed [ACC_W-1:0] h_ext;
  logic signed [ACC_W-1:0] new_acc [2];
  logic                    bank_we [2];

  assign h_ext = ACC_W'(s1_h_q);

  for (genvar b = 0; b < 2; b++) begin : g_bank
    logic signed [ACC_W-1:0] acc_mem [MAX_COARSE_WIDTH];
    logic signed [ACC_W-1:0] rd_q, wr_data_q, base, prod;
    logic [CIW-1:0]          wr_addr_q;
    logic                    wr_en_q;

    always_comb begin
      // previous write landed after this entry was read
      base       = (wr_en_q && (wr_addr_q == s1_col_q)) ? wr_data_q : rd_q;
      prod       = scale(h_ext, s1_op_q[b].wgt);
      new_acc[b] = s1_op_q[b].first ? prod : base + prod;
      bank_we[b] = s1_valid_q && s1_op_q[b].en;
    end

    always_ff @(posedge clk_i) begin
      if (bank_we[b]) begin
        acc_mem[s1_col_q] <= new_acc[b];
      end
      if (rd_en) begin
        rd_q <= acc_mem[h_col];
      end
      wr_addr_q <= s1_col_q;
      wr_data_q <= new_acc[b];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        wr_en_q <= 1'b0;
      end else begin
        wr_en_q <= bank_we[b];
      end
    end
  end

  // ---------------- rounding and output queue ----------------
  logic signed [ACC_W-1:0]     res_sum, res_rnd;
  logic                        push;
  logic [RES_W-1:0]            push_data, head_data;
  logic [FIFO_CNT_W-1:0]       fifo_cnt;

  always_comb begin
    res_sum   = (s1_res_bank_q ? new_acc[1] : new_acc[0]) + ACC_W'(ROUND_BIAS);
    res_rnd   = res_sum >>> FRAC_SHIFT;  // floor, so halves go up
    push      = s1_valid_q && s1_res_valid_q;
    push_data = {res_rnd[SAMPLE_BITS-1:0], COORD_W'(s1_col_q), COORD_W'(s1_row_q),
                 s1_flast_q};
  end

  // reserve room for a result still in stage 1 plus one from this request
  assign in_stall_o = ((FIFO_CNT_W+1)'(fifo_cnt) + (FIFO_CNT_W+1)'(push))
                      >= (FIFO_CNT_W+1)'(FIFO_DEPTH);

  mgr_out_fifo #(
    .DATA_W (RES_W)
  ) u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .count_o     (fifo_cnt),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (head_data)
  );

  assign {coarse_value_o, coarse_col_o, coarse_row_o, frame_last_o} = head_data;

  // ---------------- assertions ----------------
  a_fifo_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (32'(fifo_cnt) < FIFO_DEPTH || (out_valid_o && !out_stall_i)))
    else $error("result pushed into a full output queue");

  a_s1_has_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (s1_op_q[0].en || s1_op_q[1].en))
    else $error("stage 1 active with no bank update");

  a_res_bank_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> s1_op_q[s1_res_bank_q].en)
    else $error("result taken from a bank that was not updated");

  a_one_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> !(s1_op_q[0].first && s1_op_q[1].first))
    else $error("both row banks restarted by one horizontal sum");

endmodule

// ----- verif/mgr_restriction_checker.sv -----
// Result checker for the 2:1 multigrid restriction: register tracking, prediction, compare.
`timescale 1ns / 1ps

module mgr_restriction_checker #(
  parameter int MAX_COARSE_WIDTH = 1024,
  parameter int SAMPLE_BITS      = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mgr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mgr_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic signed [SAMPLE_BITS-1:0] coarse_value_i,
  input  logic [mgr_pkg::COORD_W-1:0]   coarse_col_i,
  input  logic [mgr_pkg::COORD_W-1:0]   coarse_row_i,
  input  logic                          frame_last_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o,
  output int unsigned                   checked_o
);
  import mgr_pkg::*;

  localparam int HSUM_W = SAMPLE_BITS + 8;
  localparam int VSUM_W = SAMPLE_BITS + 12;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic [COORD_W-1:0]            col;
    logic [COORD_W-1:0]            row;
    logic                          last;
  } coarse_t;

  // one contribution of a fine index to a coarse index, weight in eighths
  typedef struct {
    int unsigned idx;
    int          weight;
    bit          opens;
    bit          closes;
  } tap_t;

  logic [CFG_W-1:0]          grid_width, grid_height;
  bit                        stag_x, stag_y;
  int unsigned               col_pos, row_pos;
  logic signed [HSUM_W-1:0]  hsum_by_parity [2];
  logic signed [VSUM_W-1:0]  vsum_bank [2*MAX_COARSE_WIDTH];
  coarse_t                   coarse_expected [$];
  int unsigned               fails, checked;

  function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v == '0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic int axis_taps(input int unsigned pos, input int unsigned n, input bit stag,
                                   output tap_t taps[2]);
    int unsigned k;
    int          cnt;
    k   = pos >> 1;
    cnt = 0;
    taps[0] = '{0, 0, 1'b0, 1'b0};
    taps[1] = '{0, 0, 1'b0, 1'b0};
    if (stag) begin
      if (pos % 2 == 0) begin
        taps[0] = '{k, 8, 1'b1, 1'b1};
        cnt = 1;
      end
    end else if (pos % 2 == 0) begin
      // even fine index: near tap of k, far tap closing k-1; left edge folds into k
      taps[0] = '{k, (k == 0) ? 4 : 3, k == 0, 1'b0};
      cnt = 1;
      if (k >= 1) begin
        taps[1] = '{k - 1, 1, 1'b0, 1'b1};
        cnt = 2;
      end
    end else begin
      // odd fine index: near tap of k, far tap opening k+1; right edge folds into k
      taps[0] = '{k, (k + 1 == n) ? 4 : 3, 1'b0, k + 1 == n};
      cnt = 1;
      if (k + 1 < n) begin
        taps[1] = '{k + 1, 1, 1'b1, 1'b0};
        cnt = 2;
      end
    end
    return cnt;
  endfunction

  task automatic restrict_sample(input logic signed [SAMPLE_BITS-1:0] s);
    int unsigned              nx, ny, fw, fh, slot;
    tap_t                     ht[2], vt[2];
    int                       hc, vc, a, b;
    logic signed [HSUM_W-1:0] h;
    logic signed [VSUM_W-1:0] rounded;
    coarse_t                  r;
    nx = clamp_size(grid_width, MAX_COARSE_WIDTH);
    ny = clamp_size(grid_height, HEIGHT_LIMIT);
    fw = stag_x ? 2 * nx - 1 : 2 * nx;
    fh = stag_y ? 2 * ny - 1 : 2 * ny;
    // a shrunk grid puts a counter past its end: restart it
    if (col_pos >= fw) col_pos = 0;
    if (row_pos >= fh) row_pos = 0;
    hc = axis_taps(col_pos, nx, stag_x, ht);
    vc = axis_taps(row_pos, ny, stag_y, vt);
    for (a = 0; a < hc; a++) begin
      if (ht[a].opens) hsum_by_parity[ht[a].idx % 2] = ht[a].weight * s;
      else hsum_by_parity[ht[a].idx % 2] = hsum_by_parity[ht[a].idx % 2] + ht[a].weight * s;
      if (ht[a].closes) begin
        h = hsum_by_parity[ht[a].idx % 2];
        for (b = 0; b < vc; b++) begin
          slot = (vt[b].idx % 2) * MAX_COARSE_WIDTH + ht[a].idx;
          if (vt[b].opens) vsum_bank[slot] = vt[b].weight * h;
          else vsum_bank[slot] = vsum_bank[slot] + vt[b].weight * h;
          if (vt[b].closes) begin
            // floor of (sum + half) / 64, halves go toward plus infinity
            rounded = (vsum_bank[slot] + ROUND_BIAS) >>> FRAC_SHIFT;
            r.value = rounded[SAMPLE_BITS-1:0];
            r.col   = COORD_W'(ht[a].idx);
            r.row   = COORD_W'(vt[b].idx);
            r.last  = (ht[a].idx + 1 == nx) && (vt[b].idx + 1 == ny);
            coarse_expected.insert(coarse_expected.size(), r);
          end
        end
      end
    end
    col_pos++;
    if (col_pos >= fw) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= fh) row_pos = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    coarse_t want;
    if (!rst_ni) begin
      grid_width        = CFG_W'(1);
      grid_height       = CFG_W'(1);
      stag_x            = 1'b0;
      stag_y            = 1'b0;
      col_pos           = 0;
      row_pos           = 0;
      hsum_by_parity[0] = '0;
      hsum_by_parity[1] = '0;
      coarse_expected.delete();
      fails             = 0;
      checked           = 0;
      fail_count_o     <= 0;
      pending_o        <= 0;
      checked_o        <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_COARSE_WIDTH:  grid_width  = cfg_data_i;
          CFG_COARSE_HEIGHT: grid_height = cfg_data_i;
          CFG_STAGGER_X:     stag_x      = cfg_data_i[0];
          CFG_STAGGER_Y:     stag_y      = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) restrict_sample(sample_i);
      if (out_valid_i && !out_stall_i) begin
        if (coarse_expected.size() == 0) begin
          fails++;
          $display("%0t: unexpected coarse value %0d at col %0d row %0d", $time,
                   coarse_value_i, coarse_col_i, coarse_row_i);
        end else begin
          want = coarse_expected.pop_front();
          checked++;
          if (coarse_value_i !== want.value) begin
            fails++;
            $display("%0t: coarse_value expected %0d got %0d (col %0d row %0d)", $time,
                     want.value, coarse_value_i, want.col, want.row);
          end
          if (coarse_col_i !== want.col) begin
            fails++;
            $display("%0t: coarse_col expected %0d got %0d", $time, want.col, coarse_col_i);
          end
          if (coarse_row_i !== want.row) begin
            fails++;
            $display("%0t: coarse_row expected %0d got %0d", $time, want.row, coarse_row_i);
          end
          if (frame_last_i !== want.last) begin
            fails++;
            $display("%0t: frame_last expected %0b got %0b (col %0d row %0d)", $time,
                     want.last, frame_last_i, want.col, want.row);
          end
        end
      end
      pending_o    <= coarse_expected.size();
      fail_count_o <= fails;
      checked_o    <= checked;
    end
  end

endmodule

// ----- verif/tb_multigrid_restriction_2d.sv -----
// Testbench top for the 2:1 multigrid restriction: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_multigrid_restriction_2d;
  import mgr_pkg::*;

  localparam int MAX_COARSE_WIDTH = 1024;
  localparam int SAMPLE_BITS      = 32;
  localparam int ITEM_TARGET      = 1950;
  localparam int LONG_RUN         = 300;
  localparam int LIMIT_CYCLES     = 1_000_000;
  localparam int DRAIN_CYCLES     = 16;
  localparam int HOLD_OFF_CYCLES  = 400;

  logic                          clk, rst_n;
  logic                          cfg_we;
  cfg_idx_e                      cfg_idx;
  logic [CFG_W-1:0]              cfg_data;
  logic                          in_valid, in_stall;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          out_valid, out_stall;
  logic signed [SAMPLE_BITS-1:0] coarse_value;
  logic [COORD_W-1:0]            coarse_col, coarse_row;
  logic                          frame_last;
  int unsigned                   fail_count, pending, checked;

  int in_gap_max;
  bit hold_req;
  int samples_sent, directed_sent, grid_settings, cycles;

  multigrid_restriction_2d #(
    .MAX_COARSE_WIDTH(MAX_COARSE_WIDTH),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .sample_i      (sample),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .coarse_value_o(coarse_value),
    .coarse_col_o  (coarse_col),
    .coarse_row_o  (coarse_row),
    .frame_last_o  (frame_last)
  );

  mgr_restriction_checker #(
    .MAX_COARSE_WIDTH(MAX_COARSE_WIDTH),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) restriction_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .sample_i      (sample),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .coarse_value_i(coarse_value),
    .coarse_col_i  (coarse_col),
    .coarse_row_i  (coarse_row),
    .frame_last_i  (frame_last),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // fine samples along one axis for a register value and stagger mode
  function automatic int fine_len(input logic [CFG_W-1:0] reg_val, input int hi, input bit stag);
    int n;
    n = (reg_val == '0) ? 1 : ((reg_val > hi) ? hi : reg_val);
    return stag ? 2 * n - 1 : 2 * n;
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // upper bits of the stagger registers carry junk; only bit 0 counts
  task automatic set_grid(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                          input bit sx, input bit sy);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(CFG_COARSE_WIDTH, w);
    write_reg(CFG_COARSE_HEIGHT, h);
    write_reg(CFG_STAGGER_X, {junk[CFG_W-1:1], sx});
    write_reg(CFG_STAGGER_Y, {junk[CFG_W+9:CFG_W+0], sy});
    cfg_we <= 1'b0;
    grid_settings++;
  endtask

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
  endtask

  task automatic send_run(input int count);
    repeat (count) begin
      case ($urandom_range(0, 11))
        0:       send_sample({1'b0, {(SAMPLE_BITS-1){1'b1}}});
        1:       send_sample({1'b1, {(SAMPLE_BITS-1){1'b0}}});
        2:       send_sample('0);
        3:       send_sample('1);
        default: send_sample($urandom);
      endcase
    end
  endtask

  // wait for every pending result, then for the pipeline to empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result sink: random stall per request, quiet stretches, one long hold-off
  initial begin : result_sink
    int gap, rx_gap_max, taken;
    bit held;
    rx_gap_max = 10;
    taken      = 0;
    held       = 1'b0;
    forever begin
      if (taken % 40 == 0) rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
      gap = $urandom_range(0, rx_gap_max);
      if (hold_req && !held) begin
        gap  = HOLD_OFF_CYCLES;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int               len, n, phase;
    logic [CFG_W-1:0] w, h;
    bit               sx, sy;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= CFG_COARSE_WIDTH;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    sample        <= '0;
    in_gap_max    = 10;
    hold_req      = 1'b0;
    samples_sent  = 0;
    grid_settings = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single point grid
    set_grid(CFG_W'(1), CFG_W'(1), 1'b1, 1'b1);
    send_sample(32'sh7fff_ffff);
    drain();

    // 2x2 centered, extremes, stopped mid-frame at fine row 2 col 3
    set_grid(CFG_W'(2), CFG_W'(2), 1'b0, 1'b0);
    send_sample(32'sh7fff_ffff);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7fff_ffff);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7fff_ffff);
    send_sample(32'sh7fff_ffff);
    send_sample(32'sh7fff_ffff);
    send_sample(32'sh7fff_ffff);
    send_sample('0);
    send_sample(-1);
    send_sample(32'sh8000_0000);
    drain();

    // shrink to 1x1 centered: both counters lie past the new grid and restart.
    // sample 2 at weight 16/64 lands exactly on a half and rounds up
    set_grid(CFG_W'(1), CFG_W'(1), 1'b0, 1'b0);
    send_sample(2);
    send_sample('0);
    send_sample('0);
    send_sample('0);
    drain();

    // negative half (-1 at weight 32/64) rounds toward plus infinity
    set_grid(CFG_W'(1), CFG_W'(1), 1'b0, 1'b1);
    send_sample(-1);
    send_sample('0);
    drain();
    directed_sent = samples_sent;

    phase = 0;
    while (samples_sent < ITEM_TARGET) begin
      if (phase == 1) begin
        // widest grid, width register saturates; sender keeps pushing while the sink
        // holds off; the frame is cut short and a point grid resets both counters
        hold_req   = 1'b1;
        in_gap_max = 0;
        set_grid(CFG_W'(2047), CFG_W'(1), 1'b1, 1'b1);
        send_run(LONG_RUN);
        drain();
        set_grid(CFG_W'(1), CFG_W'(1), 1'b1, 1'b1);
        send_run(1);
        drain();
      end else if (phase == 3) begin
        // tallest grid, height register saturates; cut short the same way
        in_gap_max = ($urandom_range(0, 1) == 0) ? 0 : 10;
        set_grid(CFG_W'(0), CFG_W'(2047), 1'b1, 1'b0);
        send_run(LONG_RUN);
        drain();
        set_grid(CFG_W'(1), CFG_W'(1), 1'b1, 1'b1);
        send_run(1);
        drain();
      end else begin
        w  = CFG_W'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8));
        h  = CFG_W'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6));
        sx = 1'($urandom_range(0, 1));
        sy = 1'($urandom_range(0, 1));
        in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
        set_grid(w, h, sx, sy);
        len = fine_len(w, MAX_COARSE_WIDTH, sx) * fine_len(h, HEIGHT_LIMIT, sy);
        if (len > 1 && $urandom_range(0, 5) == 0) begin
          // broken frame; a point grid afterwards brings both counters back to zero
          n = $urandom_range(1, len - 1);
          send_run(n);
          drain();
          set_grid(CFG_W'(1), CFG_W'(1), 1'b1, 1'b1);
          send_run($urandom_range(1, 3));
          drain();
        end else begin
          n = len * $urandom_range(1, 3);
          send_run(n);
          drain();
        end
      end
      phase++;
    end

    $display("Run covered %0d fine samples (%0d directed) over %0d grid settings,",
             samples_sent, directed_sent, grid_settings);
    $display("  %0d coarse values checked, with cut-short frames on saturated width and height",
             checked);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/mgr_pkg.sv
sv/mgr_out_fifo.sv
sv/multigrid_restriction_2d.sv
verif/mgr_restriction_checker.sv
verif/tb_multigrid_restriction_2d.sv
